// ===== sv/sfd_pkg.sv =====
// shared constants, codes and types of the sensor frame deframer
package sfd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 17;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // framing bytes
  localparam logic [BYTE_W-1:0] HDR_FIRST   = 8'h53;
  localparam logic [BYTE_W-1:0] HDR_SECOND  = 8'h59;
  localparam logic [BYTE_W-1:0] TAIL_FIRST  = 8'h54;
  localparam logic [BYTE_W-1:0] TAIL_SECOND = 8'h43;

  // register reset values
  localparam logic [BYTE_W-1:0] BREATH_WORD_RST = 8'h81;
  localparam logic [BYTE_W-1:0] HEART_WORD_RST  = 8'h85;
  localparam logic [BYTE_W-1:0] REPORT_WORD_RST = 8'h02;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BREATH_WORD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEART_WORD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPORT_WORD = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_BREATH  = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_HEART   = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_OTHER   = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_BAD_TAIL = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_BAD_SUM = 3'd4;

  typedef struct packed {
    logic [BYTE_W-1:0] breath_word;
    logic [BYTE_W-1:0] heart_word;
    logic [BYTE_W-1:0] report_word;
  } cfg_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   control;
    logic [BYTE_W-1:0]   command;
    logic [BYTE_W-1:0]   breath;
    logic [BYTE_W-1:0]   heart;
  } result_t;

endpackage

// ===== sv/sfd_ifs.sv =====
// channel interfaces of the sensor frame deframer
interface sfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfd_status_if;
  logic       valid;
  logic       ready;
  logic [2:0] frame_status;
  logic [7:0] frame_control;
  logic [7:0] frame_command;
  logic [7:0] breath_rate;
  logic [7:0] heart_rate;

  modport source (output valid, output frame_status, output frame_control,
                  output frame_command, output breath_rate, output heart_rate,
                  input ready);
  modport sink   (input valid, input frame_status, input frame_control,
                  input frame_command, input breath_rate, input heart_rate,
                  output ready);
endinterface

// ===== sv/sensor_frame_deframer.sv =====
// top level of the sensor frame deframer
//
// byte-serial deframer for sensor report frames: one rx byte is taken per
// cycle, the frame is tracked with a running 8-bit sum and the last two bytes
// instead of a buffer, and one status item comes out when a frame ends
// (header 0x53 0x59, control, command, 16-bit big-endian length, payload,
// checksum, tail 0x54 0x43). an item passes an input register, the parse
// step and a result register; one byte per cycle is sustained as long as
// status items are taken, and the result register stalls input only when a
// frame end meets a result still waiting. the three control words are plain
// write-only registers; the user must change them only while no frame is in
// flight, and the block itself does not enforce it
module sensor_frame_deframer (
  input  logic                          clk,
  input  logic                          rst,
  sfd_byte_if.sink                      rx,
  sfd_status_if.source                  status,
  input  logic                          cfg_we,
  input  logic [sfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sfd_pkg::BYTE_W-1:0]    cfg_data
);

  // control word registers
  sfd_pkg::cfg_t cfg;

  // input register to parser
  logic                       s1_valid;
  logic [sfd_pkg::BYTE_W-1:0] s1_byte;
  logic                       s1_take;

  // parser to result register
  logic             res_valid;
  sfd_pkg::result_t res;
  logic             out_free;
  sfd_pkg::result_t out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.breath_word <= sfd_pkg::BREATH_WORD_RST;
      cfg.heart_word  <= sfd_pkg::HEART_WORD_RST;
      cfg.report_word <= sfd_pkg::REPORT_WORD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sfd_pkg::CFG_BREATH_WORD: cfg.breath_word <= cfg_data;
        sfd_pkg::CFG_HEART_WORD:  cfg.heart_word  <= cfg_data;
        sfd_pkg::CFG_REPORT_WORD: cfg.report_word <= cfg_data;
        default: begin
          // index past the last register: write dropped
        end
      endcase
    end
  end

  sfd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (rx.valid),
    .in_byte    (rx.rx_byte),
    .in_ready   (rx.ready),
    .held_valid (s1_valid),
    .held_byte  (s1_byte),
    .held_take  (s1_take)
  );

  // parse step: one byte per cycle unless a frame end waits for the result register, emits at most one status per byte
  sfd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_byte   (s1_byte),
    .in_take   (s1_take),
    .cfg       (cfg),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res)
  );

  sfd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .load_data (res),
    .free      (out_free),
    .out_valid (status.valid),
    .out_data  (out_data),
    .out_ready (status.ready)
  );

  assign status.frame_status  = out_data.status;
  assign status.frame_control = out_data.control;
  assign status.frame_command = out_data.command;
  assign status.breath_rate   = out_data.breath;
  assign status.heart_rate    = out_data.heart;

endmodule

// ===== sv/sfd_in_reg.sv =====
// input register stage of the sensor frame deframer
module sfd_in_reg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [sfd_pkg::BYTE_W-1:0] in_byte,
  output logic                      in_ready,
  output logic                      held_valid,
  output logic [sfd_pkg::BYTE_W-1:0] held_byte,
  input  logic                      held_take
);

  logic s1_valid;
  logic [sfd_pkg::BYTE_W-1:0] s1_byte;

  assign in_ready   = !s1_valid || held_take;
  assign held_valid = s1_valid;
  assign held_byte  = s1_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= in_byte;
    end
  end

endmodule

// ===== sv/sfd_parser.sv =====
// frame state, running checksum and status decision of the deframer
module sfd_parser (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [sfd_pkg::BYTE_W-1:0] in_byte,
  output logic                       in_take,
  input  sfd_pkg::cfg_t              cfg,
  input  logic                       out_free,
  output logic                       res_valid,
  output sfd_pkg::result_t           res
);

  localparam logic [1:0] PH_HUNT1 = 2'd0;
  localparam logic [1:0] PH_HUNT2 = 2'd1;
  localparam logic [1:0] PH_BODY  = 2'd2;

  localparam logic [sfd_pkg::COUNT_W-1:0] POS_CONTROL = 17'd2;
  localparam logic [sfd_pkg::COUNT_W-1:0] POS_COMMAND = 17'd3;
  localparam logic [sfd_pkg::COUNT_W-1:0] POS_LEN_HI  = 17'd4;
  localparam logic [sfd_pkg::COUNT_W-1:0] POS_LEN_LO  = 17'd5;
  localparam logic [sfd_pkg::COUNT_W-1:0] POS_FIRST   = 17'd6;
  localparam logic [sfd_pkg::COUNT_W-1:0] FRAME_EXTRA = 17'd8;

  logic [1:0]                      phase, phase_next;
  logic [sfd_pkg::COUNT_W-1:0]     byte_count, byte_count_next;
  logic [sfd_pkg::LEN_W-1:0]       payload_length, payload_length_next;
  logic [sfd_pkg::BYTE_W-1:0]      control_byte, control_byte_next;
  logic [sfd_pkg::BYTE_W-1:0]      command_byte, command_byte_next;
  logic [sfd_pkg::BYTE_W-1:0]      first_byte, first_byte_next;
  logic [sfd_pkg::BYTE_W-1:0]      running_sum, running_sum_next;
  logic [sfd_pkg::BYTE_W-1:0]      prev0, prev0_next;
  logic [sfd_pkg::BYTE_W-1:0]      prev1, prev1_next;
  logic [sfd_pkg::BYTE_W-1:0]      held_breath, held_breath_next;
  logic [sfd_pkg::BYTE_W-1:0]      held_heart, held_heart_next;

  logic                            frame_end;
  logic                            fire;
  logic                            tail_ok;
  logic                            sum_ok;
  logic                            is_report;
  logic [sfd_pkg::BYTE_W-1:0]      expect_sum;
  logic [sfd_pkg::STATUS_W-1:0]    status;

  // the last byte of a frame sits at position 8 plus length
  assign frame_end = (phase == PH_BODY) &&
                     (byte_count == ({1'b0, payload_length} + FRAME_EXTRA));
  assign fire      = in_valid && (!frame_end || out_free);
  assign in_take   = fire;
  assign res_valid = fire && frame_end;

  assign tail_ok    = (in_byte == sfd_pkg::TAIL_SECOND) && (prev0 == sfd_pkg::TAIL_FIRST);
  assign expect_sum = running_sum - prev0 - prev1;
  assign sum_ok     = (expect_sum == prev1);
  assign is_report  = (command_byte == cfg.report_word);

  always_comb begin
    phase_next          = phase;
    byte_count_next     = byte_count;
    payload_length_next = payload_length;
    control_byte_next   = control_byte;
    command_byte_next   = command_byte;
    first_byte_next     = first_byte;
    running_sum_next    = running_sum;
    prev0_next          = prev0;
    prev1_next          = prev1;
    held_breath_next    = held_breath;
    held_heart_next     = held_heart;
    status              = sfd_pkg::STATUS_OTHER;

    if (fire) begin
      unique case (phase)
        PH_HUNT2: begin
          if (in_byte == sfd_pkg::HDR_SECOND) begin
            phase_next       = PH_BODY;
            running_sum_next = running_sum + in_byte;
            prev1_next       = prev0;
            prev0_next       = in_byte;
            byte_count_next  = byte_count + 17'd1;
          end else begin
            phase_next          = PH_HUNT1;
            byte_count_next     = '0;
            payload_length_next = '0;
            control_byte_next   = '0;
            command_byte_next   = '0;
            first_byte_next     = '0;
            running_sum_next    = '0;
            prev0_next          = '0;
            prev1_next          = '0;
          end
        end
        PH_BODY: begin
          if (frame_end) begin
            if (!tail_ok) begin
              status = sfd_pkg::STATUS_BAD_TAIL;
            end else if (!sum_ok) begin
              status = sfd_pkg::STATUS_BAD_SUM;
            end else if (control_byte == cfg.breath_word && is_report) begin
              held_breath_next = first_byte;
              status           = sfd_pkg::STATUS_BREATH;
            end else if (control_byte == cfg.heart_word && is_report) begin
              held_heart_next = first_byte;
              status          = sfd_pkg::STATUS_HEART;
            end else begin
              status = sfd_pkg::STATUS_OTHER;
            end
            phase_next          = PH_HUNT1;
            byte_count_next     = '0;
            payload_length_next = '0;
            control_byte_next   = '0;
            command_byte_next   = '0;
            first_byte_next     = '0;
            running_sum_next    = '0;
            prev0_next          = '0;
            prev1_next          = '0;
          end else begin
            if (byte_count == POS_CONTROL) begin
              control_byte_next = in_byte;
            end else if (byte_count == POS_COMMAND) begin
              command_byte_next = in_byte;
            end else if (byte_count == POS_LEN_HI) begin
              payload_length_next = {in_byte, payload_length[7:0]};
            end else if (byte_count == POS_LEN_LO) begin
              payload_length_next = {payload_length[15:8], in_byte};
            end else if (byte_count == POS_FIRST) begin
              first_byte_next = in_byte;
            end
            running_sum_next = running_sum + in_byte;
            prev1_next       = prev0;
            prev0_next       = in_byte;
            byte_count_next  = byte_count + 17'd1;
          end
        end
        default: begin
          // hunting for the first header byte, frame state starts clean
          payload_length_next = '0;
          control_byte_next   = '0;
          command_byte_next   = '0;
          first_byte_next     = '0;
          if (in_byte == sfd_pkg::HDR_FIRST) begin
            phase_next       = PH_HUNT2;
            running_sum_next = in_byte;
            prev1_next       = '0;
            prev0_next       = in_byte;
            byte_count_next  = 17'd1;
          end else begin
            phase_next       = PH_HUNT1;
            running_sum_next = '0;
            prev1_next       = '0;
            prev0_next       = '0;
            byte_count_next  = '0;
          end
        end
      endcase
    end
  end

  always_comb begin
    res.status  = status;
    res.control = control_byte;
    res.command = command_byte;
    res.breath  = held_breath_next;
    res.heart   = held_heart_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT1;
      byte_count     <= '0;
      payload_length <= '0;
      control_byte   <= '0;
      command_byte   <= '0;
      first_byte     <= '0;
      running_sum    <= '0;
      prev0          <= '0;
      prev1          <= '0;
      held_breath    <= '0;
      held_heart     <= '0;
    end else begin
      phase          <= phase_next;
      byte_count     <= byte_count_next;
      payload_length <= payload_length_next;
      control_byte   <= control_byte_next;
      command_byte   <= command_byte_next;
      first_byte     <= first_byte_next;
      running_sum    <= running_sum_next;
      prev0          <= prev0_next;
      prev1          <= prev1_next;
      held_breath    <= held_breath_next;
      held_heart     <= held_heart_next;
    end
  end

endmodule

// ===== sv/sfd_out_reg.sv =====
// result register of the sensor frame deframer
module sfd_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  sfd_pkg::result_t load_data,
  output logic             free,
  output logic             out_valid,
  output sfd_pkg::result_t out_data,
  input  logic             out_ready
);

  logic             valid;
  sfd_pkg::result_t data;

  assign free      = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      data <= load_data;
    end
  end

endmodule

// ===== sv/sfd_checker.sv =====
// port checks of the sensor frame deframer and their binding
module sfd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [sfd_pkg::STATUS_W-1:0]  frame_status,
  input logic [sfd_pkg::BYTE_W-1:0]    breath_rate,
  input logic [sfd_pkg::BYTE_W-1:0]    heart_rate
);

  logic [sfd_pkg::BYTE_W-1:0] last_breath;
  logic [sfd_pkg::BYTE_W-1:0] last_heart;

  // rates of the last delivered status item
  always_ff @(posedge clk) begin
    if (rst) begin
      last_breath <= '0;
      last_heart  <= '0;
    end else if (out_valid && out_ready) begin
      last_breath <= breath_rate;
      last_heart  <= heart_rate;
    end
  end

  a_no_out_after_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("status item right after reset");

  a_out_held: assert property (@(posedge clk) disable iff (rst)
      out_valid && !out_ready |=> out_valid)
    else $error("status item dropped while stalled");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
      out_valid |-> frame_status <= sfd_pkg::STATUS_BAD_SUM)
    else $error("status code out of range");

  a_breath_kept: assert property (@(posedge clk) disable iff (rst)
      out_valid && frame_status != sfd_pkg::STATUS_BREATH |-> breath_rate == last_breath)
    else $error("breath rate changed without a breath report");

  a_heart_kept: assert property (@(posedge clk) disable iff (rst)
      out_valid && frame_status != sfd_pkg::STATUS_HEART |-> heart_rate == last_heart)
    else $error("heart rate changed without a heart report");

endmodule

bind sensor_frame_deframer sfd_checker u_sfd_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (status.valid),
  .out_ready    (status.ready),
  .frame_status (status.frame_status),
  .breath_rate  (status.breath_rate),
  .heart_rate   (status.heart_rate)
);
